// ----- rtl/mwr_pkg.sv -----
// Shared constants for the moving-window RMS block.
`default_nettype none

package mwr_pkg;

    // Sample and window sizing.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 256;
    localparam int IDX_W       = $clog2(MAX_WINDOW);
    localparam int FILL_W      = IDX_W + 1;
    localparam int CFG_W       = 9;

    // Arithmetic widths derived from the sample width.
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_W + IDX_W;
    localparam int ROOT_W = SAMPLE_BITS;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Step counters of the serial units.
    localparam int SQR_CNT_W  = $clog2(SAMPLE_BITS + 1);
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    // Window length after reset.
    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(16);

    typedef logic [SAMPLE_BITS-1:0] mag_t;
    typedef logic [SQ_W-1:0]        square_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [FILL_W-1:0]      fill_t;
    typedef logic [ROOT_W-1:0]      root_t;

endpackage

`default_nettype wire

// ----- rtl/mwr_sqr.sv -----
// Bit-serial shift-and-add squarer, one multiplier bit per cycle.
`default_nettype none

module mwr_sqr (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire mwr_pkg::mag_t      mag,
    output logic                    done,
    output mwr_pkg::square_t        square
);
    import mwr_pkg::*;

    logic [SAMPLE_BITS-1:0] acc_reg, acc_next;
    logic [SAMPLE_BITS-1:0] mplr_reg, mplr_next;
    logic [SAMPLE_BITS-1:0] mcand_reg, mcand_next;
    logic [SQR_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SAMPLE_BITS:0]   add_sum;
    logic [PROD_W-1:0]      product;

    // One partial product is added per cycle, then the pair shifts right.
    always_comb
    begin
        add_sum = {1'b0, acc_reg} + (mplr_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next   = acc_reg;
        mplr_next  = mplr_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            acc_next   = '0;
            mplr_next  = mag;
            mcand_next = mag;
            cnt_next   = SQR_CNT_W'(SAMPLE_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = add_sum[SAMPLE_BITS:1];
            mplr_next = {add_sum[0], mplr_reg[SAMPLE_BITS-1:1]};
            cnt_next  = cnt_reg - SQR_CNT_W'(1);
            if (cnt_reg == SQR_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mplr_reg  <= mplr_next;
        mcand_reg <= mcand_next;
    end

    assign product = {acc_reg, mplr_reg};
    assign square  = product[SQ_W-1:0];
    assign done    = done_reg;

endmodule

`default_nettype wire

// ----- rtl/mwr_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mwr_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire mwr_pkg::sum_t   dividend,
    input  wire mwr_pkg::fill_t  divisor,
    output logic                 done,
    output mwr_pkg::sum_t        quotient
);
    import mwr_pkg::*;

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [FILL_W-1:0]    rem_reg, rem_next;
    logic [FILL_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [FILL_W:0]      trial;
    logic [FILL_W:0]      diff;
    logic                 fits;

    // Bring down the next dividend bit and subtract when the divisor fits.
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/mwr_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module mwr_sqrt (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire [mwr_pkg::RAD_W-1:0] radicand,
    output logic                   done,
    output mwr_pkg::root_t         root
);
    import mwr_pkg::*;

    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [REM_W+1:0]      shifted;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      diff;
    logic                  fits;

    // Bring in two radicand bits and try the next root bit.
    always_comb
    begin
        shifted = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial   = {2'b00, root_reg, 2'b01};
        fits    = (shifted >= trial);
        diff    = shifted - trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = ROOT_CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - ROOT_CNT_W'(1);
            if (cnt_reg == ROOT_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- rtl/moving_window_rms_unit.sv -----
// Moving-window RMS: one floored root of the mean square per input sample.
//
// The sample channel (sample_valid/sample_ready) takes one signed word per
// handshake. The result channel (result_valid/result_ready) returns one word
// per sample: rms_value, the floored square root of the truncated mean of
// the squares in the window, and window_full, set once the window holds
// window_length squares. The cfg channel writes window_length; zero counts
// as one and values above 256 count as 256. Write it only while idle.
//
// Each sample passes from acceptance through the serial squarer, the
// bit-serial divider (one quotient bit per cycle) and the serial square
// root, with control states between them, before its result word is valid.
// The divider takes the longest of these units. One sample is processed at
// a time, so a new sample is taken only once the last result is loaded.
// A finished result sits in the output register, so the next sample is
// taken while it waits; a stalled receiver holds only the next result.
//
// Reset clears the running sum, fill count and ring pointer and sets
// window_length to 16. The square ring needs no clearing: only entries
// written since reset are read back.
`default_nettype none

module moving_window_rms_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          sample_valid,
    output logic                         sample_ready,
    input  wire signed [mwr_pkg::SAMPLE_BITS-1:0] sample,
    output logic                         result_valid,
    input  wire                          result_ready,
    output logic [mwr_pkg::ROOT_W-1:0]   rms_value,
    output logic                         window_full,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [mwr_pkg::CFG_W-1:0]     cfg_data
);
    import mwr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUB  = 3'd1;
    localparam logic [2:0] ST_SQR  = 3'd2;
    localparam logic [2:0] ST_DIVS = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] win_reg, win_next;
    logic [IDX_W-1:0] head_reg, head_next;
    fill_t            fill_reg, fill_next;
    sum_t             sum_reg, sum_next;
    logic             sub_reg, sub_next;
    logic             full_reg, full_next;
    logic             res_valid_reg, res_valid_next;
    root_t            res_root_reg;
    logic             res_full_reg;

    square_t          ring_mem [MAX_WINDOW];
    square_t          old_sq_reg;
    logic [IDX_W-1:0] old_idx;
    logic             ring_we;

    fill_t            win_eff;
    fill_t            fill_inc;
    mag_t             mag;
    logic             accept;
    logic             load_out;
    logic             sqr_done;
    square_t          square;
    logic             div_start;
    logic             div_done;
    sum_t             quotient;
    logic             root_done;
    root_t            root;

    // Effective window: zero counts as one, large values saturate.
    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = FILL_W'(1);
        end
        else if (FILL_W'(win_reg) > FILL_W'(MAX_WINDOW))
        begin
            win_eff = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = FILL_W'(win_reg);
        end
    end

    assign fill_inc     = fill_reg + FILL_W'(1);
    assign mag          = sample[SAMPLE_BITS-1] ? (~sample + mag_t'(1)) : sample;
    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;
    assign old_idx      = head_reg - fill_reg[IDX_W-1:0];
    assign load_out     = (state_reg == ST_OUT) && (!res_valid_reg || result_ready);
    assign ring_we      = (state_reg == ST_SQR) && sqr_done;
    assign div_start    = (state_reg == ST_DIVS);

    // Sequencer and window bookkeeping.
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        sub_next       = sub_reg;
        full_next      = full_reg;
        res_valid_next = res_valid_reg;
        if (cfg_valid)
        begin
            win_next = cfg_data;
        end
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sub_next = (fill_reg >= win_eff);
                    if (fill_reg >= win_eff)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                        full_next = (fill_inc >= win_eff);
                    end
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                // Drop the oldest square when the window is full.
                if (sub_reg)
                begin
                    sum_next = sum_reg - SUM_W'(old_sq_reg);
                end
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (sqr_done)
                begin
                    sum_next   = sum_reg + SUM_W'(square);
                    head_next  = head_reg + IDX_W'(1);
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= WIN_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sub_reg       <= 1'b0;
            full_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            sub_reg       <= sub_next;
            full_reg      <= full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Square ring: the oldest entry is read at acceptance, the new one written later.
    always_ff @(posedge clk)
    begin
        old_sq_reg <= ring_mem[old_idx];
        if (ring_we)
        begin
            ring_mem[head_reg] <= square;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_root_reg <= root;
            res_full_reg <= full_reg;
        end
    end

    mwr_sqr u_sqr (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mag    (mag),
        .done   (sqr_done),
        .square (square)
    );

    mwr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    mwr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_done),
        .radicand (RAD_W'(quotient[SQ_W-1:0])),
        .done     (root_done),
        .root     (root)
    );

    assign result_valid = res_valid_reg;
    assign rms_value    = res_root_reg;
    assign window_full  = res_full_reg;

endmodule

`default_nettype wire
